FILE: rtl/core/cbe_pkg.sv
// cubic bezier evaluator: shared types, constants and rounding helpers
// no dependencies; used by every module of the block but cbe_checker
package cbe_pkg;

  localparam int unsigned DEF_SAMPLES   = 64;
  localparam int unsigned DEF_TOLERANCE = 1280;

  localparam logic [16:0] ONE_T = 17'd65536;

  localparam logic REQ_EVAL = 1'b0;
  localparam logic REQ_HIT  = 1'b1;

  localparam logic [2:0] CFG_P0_X = 3'd0;
  localparam logic [2:0] CFG_P0_Y = 3'd1;
  localparam logic [2:0] CFG_P1_X = 3'd2;
  localparam logic [2:0] CFG_P1_Y = 3'd3;
  localparam logic [2:0] CFG_P2_X = 3'd4;
  localparam logic [2:0] CFG_P2_Y = 3'd5;
  localparam logic [2:0] CFG_P3_X = 3'd6;
  localparam logic [2:0] CFG_P3_Y = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef logic signed [34:0] mul_a_t;
  typedef logic signed [25:0] mul_b_t;
  typedef logic signed [60:0] mul_p_t;
  typedef logic signed [61:0] acc_t;

  typedef struct packed {
    logic signed [23:0] p0_x;
    logic signed [23:0] p0_y;
    logic signed [23:0] p1_x;
    logic signed [23:0] p1_y;
    logic signed [23:0] p2_x;
    logic signed [23:0] p2_y;
    logic signed [23:0] p3_x;
    logic signed [23:0] p3_y;
  } ctrl_pts_t;

  typedef struct packed {
    logic               req_type;
    logic [16:0]        param_t;
    logic signed [23:0] query_x;
    logic signed [23:0] query_y;
  } req_t;

  typedef struct packed {
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [26:0] tangent_x;
    logic signed [26:0] tangent_y;
    logic               hit;
  } res_t;

  // round half up from 2^-48 to 2^-32 units
  function automatic logic [32:0] rnd16(input logic [50:0] m);
    logic [50:0] s;
    s = m + 51'd32768;
    return s[48:16];
  endfunction

  // floor((acc + 2^31) / 2^32), clamped to the point range
  function automatic logic signed [23:0] sat_pt(input acc_t acc);
    acc_t               s;
    logic signed [29:0] r;
    s = acc + 62'sd2147483648;
    r = s[61:32];
    if (r > 30'sd8388607) return 24'sh7fffff;
    else if (r < -30'sd8388608) return 24'sh800000;
    else return r[23:0];
  endfunction

  // same rounding, clamped to the tangent range
  function automatic logic signed [26:0] sat_tg(input acc_t acc);
    acc_t               s;
    logic signed [29:0] r;
    s = acc + 62'sd2147483648;
    r = s[61:32];
    if (r > 30'sd67108863) return 27'sh3ffffff;
    else if (r < -30'sd67108864) return 27'sh4000000;
    else return r[26:0];
  endfunction

endpackage

FILE: rtl/core/cubic_bezier_eval_hit_test_core.sv
// cubic bezier evaluator / hit tester top level: control point registers,
// request and result channels; depends on cbe_pkg, cbe_seq and cbe_mul
//
// usage
//   control points are written through cfg_we / cfg_index / cfg_data (index 0..7 is
//   p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y) while no request is in flight.
//   a request is taken when in_valid is high and in_stall is low; in_stall stays high
//   while the block works on it. one result comes out per request on out_valid,
//   held in an output register until out_stall is low.
//   timing: the single shared multiplier sets the pace. a hit test sweeps SAMPLES+1
//   curve samples, with 19 multiplier steps per curve sample.
//   a new request can be taken once the result has moved to the output register,
//   so a stalled receiver holds at most one finished result while the next request
//   is accepted and computed.
//   reset restores the default control points, drops any request in flight and
//   clears out_valid.
module cubic_bezier_eval_hit_test_core #(
  parameter int unsigned SAMPLES   = cbe_pkg::DEF_SAMPLES,
  parameter int unsigned TOLERANCE = cbe_pkg::DEF_TOLERANCE
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               req_type,
  input  logic [16:0]        param_t,
  input  logic signed [23:0] query_x,
  input  logic signed [23:0] query_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] point_x,
  output logic signed [23:0] point_y,
  output logic signed [26:0] tangent_x,
  output logic signed [26:0] tangent_y,
  output logic               hit
);
  import cbe_pkg::*;

  ctrl_pts_t pts;
  req_t      req;
  res_t      res;
  logic      busy, res_valid, res_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      pts.p0_x <= 24'sd0;
      pts.p0_y <= 24'sd0;
      pts.p1_x <= 24'sd12800;
      pts.p1_y <= 24'sd25600;
      pts.p2_x <= 24'sd38400;
      pts.p2_y <= 24'sd25600;
      pts.p3_x <= 24'sd51200;
      pts.p3_y <= 24'sd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_P0_X: pts.p0_x <= cfg_data;
        CFG_P0_Y: pts.p0_y <= cfg_data;
        CFG_P1_X: pts.p1_x <= cfg_data;
        CFG_P1_Y: pts.p1_y <= cfg_data;
        CFG_P2_X: pts.p2_x <= cfg_data;
        CFG_P2_Y: pts.p2_y <= cfg_data;
        CFG_P3_X: pts.p3_x <= cfg_data;
        CFG_P3_Y: pts.p3_y <= cfg_data;
        default: ;
      endcase
    end
  end

  assign req.req_type = req_type;
  assign req.param_t  = param_t;
  assign req.query_x  = query_x;
  assign req.query_y  = query_y;

  assign in_stall = busy;
  assign res_take = !out_valid || !out_stall;

  cbe_seq #(.SAMPLES(SAMPLES), .TOLERANCE(TOLERANCE)) u_seq (
    .clk(clk), .rst(rst), .pts(pts),
    .start(in_valid && !busy), .req(req),
    .busy(busy), .res_valid(res_valid), .res_take(res_take), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      point_x   <= res.point_x;
      point_y   <= res.point_y;
      tangent_x <= res.tangent_x;
      tangent_y <= res.tangent_y;
      hit       <= res.hit;
    end
  end

endmodule

FILE: rtl/core/cbe_mul.sv
// shared signed multiplier with a registered product
// depends on cbe_pkg for operand and product types
module cbe_mul (
  input  logic            clk,
  input  cbe_pkg::mul_a_t a,
  input  cbe_pkg::mul_b_t b,
  output cbe_pkg::mul_p_t p
);
  import cbe_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

FILE: rtl/core/cbe_seq.sv
// sequencer and datapath: weights, point, tangent and sample sweep on one multiplier
// depends on cbe_pkg and cbe_mul
module cbe_seq #(
  parameter int unsigned SAMPLES   = cbe_pkg::DEF_SAMPLES,
  parameter int unsigned TOLERANCE = cbe_pkg::DEF_TOLERANCE
) (
  input  logic               clk,
  input  logic               rst,
  input  cbe_pkg::ctrl_pts_t pts,
  input  logic               start,
  input  cbe_pkg::req_t      req,
  output logic               busy,
  output logic               res_valid,
  input  logic               res_take,
  output cbe_pkg::res_t      res
);
  import cbe_pkg::*;

  localparam int unsigned CW = $clog2(SAMPLES + 1);
  localparam int unsigned RW = $clog2(SAMPLES) + 1;
  localparam logic [16:0]   STEP_Q = 17'(65536 / SAMPLES);
  localparam logic [RW-1:0] STEP_R = RW'(65536 % SAMPLES);
  localparam logic [RW-1:0] SDIV   = RW'(SAMPLES);
  localparam logic [CW-1:0] LAST   = CW'(SAMPLES);
  localparam logic [49:0]   LIM    = 50'(TOLERANCE) * 50'(TOLERANCE);

  localparam logic [4:0] S_UU = 5'd0, S_TT = 5'd1, S_W0 = 5'd2, S_W1 = 5'd3;
  localparam logic [4:0] S_W2 = 5'd4, S_W3 = 5'd5, S_X0 = 5'd6, S_X1 = 5'd7;
  localparam logic [4:0] S_X2 = 5'd8, S_X3 = 5'd9, S_Y0 = 5'd10, S_Y1 = 5'd11;
  localparam logic [4:0] S_Y2 = 5'd12, S_Y3 = 5'd13, S_DX = 5'd14, S_PY = 5'd15;
  localparam logic [4:0] S_K0X = 5'd16, S_K1X = 5'd17, S_K2X = 5'd18, S_K0Y = 5'd19;
  localparam logic [4:0] S_K1Y = 5'd20, S_K2Y = 5'd21, S_TY0 = 5'd22, S_TY = 5'd23;

  state_t state, state_next;
  logic [4:0]     step;
  logic [CW-1:0]  sample;
  logic [RW-1:0]  rem;
  logic [RW:0]    rem_sum;
  logic           mode;
  logic [16:0]    t;
  logic [16:0]    u;
  logic signed [23:0] qx, qy;
  logic [32:0]    uu, tt, w0, w1, w2, w3;
  logic [30:0]    ut;
  acc_t           acc_x, acc_y;
  logic signed [23:0] px, py;
  logic signed [26:0] tx, ty;
  logic [49:0]    dsum;
  logic           hit;
  logic           last_step;
  logic [50:0]    m1, m3;

  logic signed [24:0] d0x, d1x, d2x, d0y, d1y, d2y, dx, dy;
  logic [34:0]    k0, k1, k2;
  mul_a_t         ma;
  mul_b_t         mb;
  mul_p_t         prod;

  cbe_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(prod));

  assign u   = ONE_T - t;
  assign d0x = 25'(pts.p1_x) - 25'(pts.p0_x);
  assign d1x = 25'(pts.p2_x) - 25'(pts.p1_x);
  assign d2x = 25'(pts.p3_x) - 25'(pts.p2_x);
  assign d0y = 25'(pts.p1_y) - 25'(pts.p0_y);
  assign d1y = 25'(pts.p2_y) - 25'(pts.p1_y);
  assign d2y = 25'(pts.p3_y) - 25'(pts.p2_y);
  assign dx  = 25'(qx) - 25'(px);
  assign dy  = 25'(qy) - 25'(py);
  assign k0  = 35'(uu) + 35'({uu, 1'b0});
  assign k1  = 35'({ut, 2'b00}) + 35'({ut, 1'b0});
  assign k2  = 35'(tt) + 35'({tt, 1'b0});
  assign m1  = prod[50:0];
  assign m3  = prod[50:0] + {prod[49:0], 1'b0};
  assign rem_sum = {1'b0, rem} + {1'b0, STEP_R};

  // the evaluate pass ends on the tangent y round, a hit sample on its compare
  assign last_step = (mode == REQ_HIT) ? (step == S_K2X) : (step == S_TY);

  // operand select for the step issued this cycle
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (step)
      S_UU: begin ma = 35'(u);  mb = 26'(u); end
      S_TT: begin ma = 35'(t);  mb = 26'(t); end
      S_W0: begin ma = 35'(uu); mb = 26'(u); end
      S_W1: begin ma = 35'(uu); mb = 26'(t); end
      S_W2: begin ma = 35'(tt); mb = 26'(u); end
      S_W3: begin ma = 35'(tt); mb = 26'(t); end
      S_X0: begin ma = 35'(w0); mb = 26'(pts.p0_x); end
      S_X1: begin ma = 35'(w1); mb = 26'(pts.p1_x); end
      S_X2: begin ma = 35'(w2); mb = 26'(pts.p2_x); end
      S_X3: begin ma = 35'(w3); mb = 26'(pts.p3_x); end
      S_Y0: begin ma = 35'(w0); mb = 26'(pts.p0_y); end
      S_Y1: begin ma = 35'(w1); mb = 26'(pts.p1_y); end
      S_Y2: begin ma = 35'(w2); mb = 26'(pts.p2_y); end
      S_Y3: begin ma = 35'(w3); mb = 26'(pts.p3_y); end
      S_DX: begin
        if (mode == REQ_HIT) begin
          ma = 35'(dx); mb = 26'(dx);
        end else begin
          ma = 35'(u);  mb = 26'(t);
        end
      end
      S_K0X: begin
        if (mode == REQ_HIT) begin
          ma = 35'(dy); mb = 26'(dy);
        end else begin
          ma = k0; mb = 26'(d0x);
        end
      end
      S_K1X: begin ma = k1; mb = 26'(d1x); end
      S_K2X: begin ma = k2; mb = 26'(d2x); end
      S_K0Y: begin ma = k0; mb = 26'(d0y); end
      S_K1Y: begin ma = k1; mb = 26'(d1y); end
      S_K2Y: begin ma = k2; mb = 26'(d2y); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_RUN;
      ST_RUN: begin
        if (last_step && (mode == REQ_EVAL || sample == LAST)) state_next = ST_DONE;
      end
      ST_DONE: if (res_take) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE || last_step) step <= '0;
      else if (state == ST_RUN) step <= step + 5'd1;
    end
  end

  // load a new request on start; while running, write back the product issued in the previous step
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      if (start) begin
        mode   <= req.req_type;
        qx     <= req.query_x;
        qy     <= req.query_y;
        sample <= '0;
        rem    <= '0;
        hit    <= 1'b0;
        if (req.req_type == REQ_HIT) t <= '0;
        else if (req.param_t > ONE_T) t <= ONE_T;
        else t <= req.param_t;
      end
    end else if (state == ST_RUN) begin
      unique case (step)
        S_TT:  uu <= prod[32:0];
        S_W0:  tt <= prod[32:0];
        S_W1:  w0 <= rnd16(m1);
        S_W2:  w1 <= rnd16(m3);
        S_W3:  w2 <= rnd16(m3);
        S_X0:  w3 <= rnd16(m1);
        S_X1:  acc_x <= 62'(prod);
        S_X2, S_X3, S_Y0: acc_x <= acc_x + 62'(prod);
        S_Y1: begin
          acc_y <= 62'(prod);
          px    <= sat_pt(acc_x);
        end
        S_Y2, S_Y3, S_DX: acc_y <= acc_y + 62'(prod);
        S_PY: begin
          py <= sat_pt(acc_y);
          if (mode == REQ_HIT) dsum <= prod[49:0];
          else ut <= prod[30:0];
        end
        S_K1X: begin
          if (mode == REQ_HIT) dsum <= dsum + prod[49:0];
          else acc_x <= 62'(prod);
        end
        S_K2X: begin
          if (mode == REQ_HIT) begin
            if (dsum <= LIM) hit <= 1'b1;
            sample <= sample + CW'(1);
            if (rem_sum >= {1'b0, SDIV}) begin
              rem <= RW'(rem_sum - {1'b0, SDIV});
              t   <= t + STEP_Q + 17'd1;
            end else begin
              rem <= rem_sum[RW-1:0];
              t   <= t + STEP_Q;
            end
          end else begin
            acc_x <= acc_x + 62'(prod);
          end
        end
        S_K0Y: acc_x <= acc_x + 62'(prod);
        S_K1Y: begin
          acc_y <= 62'(prod);
          tx    <= sat_tg(acc_x);
        end
        S_K2Y, S_TY0: acc_y <= acc_y + 62'(prod);
        S_TY:  ty <= sat_tg(acc_y);
        default: ;
      endcase
    end
  end

  assign busy      = (state != ST_IDLE);
  assign res_valid = (state == ST_DONE);

  always_comb begin
    if (mode == REQ_HIT) begin
      res = '0;
      res.hit = hit;
    end else begin
      res.point_x   = px;
      res.point_y   = py;
      res.tangent_x = tx;
      res.tangent_y = ty;
      res.hit       = 1'b0;
    end
  end

endmodule

FILE: rtl/core/cbe_checker.sv
// port-level checks for the bezier evaluator top level, bound to it below
// depends only on the top level's ports
module cbe_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [23:0] point_x,
  input logic signed [23:0] point_y,
  input logic signed [26:0] tangent_x,
  input logic signed [26:0] tangent_y,
  input logic               hit
);

  // a request keeps the block busy for at least the next cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted without going busy");

  // a result never appears the cycle right after a request is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !out_valid) |=> !out_valid)
    else $error("result appeared too early");

  // a hit result carries no geometry
  a_hit_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> (point_x == 24'sd0 && point_y == 24'sd0 &&
                            tangent_x == 27'sd0 && tangent_y == 27'sd0))
    else $error("hit result with nonzero point or tangent");

  // stalled result stays valid, with point_x and hit held
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(point_x) && $stable(hit)))
    else $error("stalled result changed");

  a_reset_clear: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("out_valid set after reset");

endmodule

bind cubic_bezier_eval_hit_test_core cbe_checker u_cbe_checker (.*);
